// ===== hdl/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

  // Field widths of the item formats
  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int CELL_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int OP_W        = 3;

  // Action codes of an input transaction
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Operations handed from the front end to the back end
  localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_NOP     = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, SPACE_CODE};

  // Register index, taken from byte address bit 2
  localparam logic REG_ATTRIBUTE = 1'b0;

  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]      cell_value;
    logic [ROW_FIELD_W-1:0] cursor_row_now;
    logic [COL_FIELD_W-1:0] cursor_col_now;
    logic                   scrolled;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_col;
    logic                   in_range;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/text_console_cursor_scroll_unit.sv =====
`default_nettype none

// Channel  Handshake                     Payload / data
// input    push, full                    in_item  (action, char_code, read_row, read_col)
// result   empty, pop                    out_item (cell_value, cursor_row_now, cursor_col_now,
//                                                  scrolled)
// config   psel penable pwrite pready    paddr[2:0], pwdata, prdata (attribute at byte 0)
//
// Put character, newline without scroll and unused actions retire in the cycle they are
// popped; a read registers the cell and returns it from S_READ. One screen cell access a
// cycle sets the rest: clear blanks every cell, a scroll copies one cell a cycle one row up,
// then blanks the bottom row. After reset the back end sweeps all ROW_COUNT*COL_COUNT cells
// (2000 at the default size) to blanks and holds full high meanwhile; config writes are taken throughout.
// The command queue lets the front accept transactions while the back end walks the
// screen; the result queue lets the back end run on while the consumer holds off pop.

module text_console_cursor_scroll_unit import tccs_pkg::*; #(
  parameter int ROW_COUNT = 25,
  parameter int COL_COUNT = 80,
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              cfg_wr;

  cmd_t              cmd_in, cmd_out;
  logic [$bits(cmd_t)-1:0]      cmd_rdata;
  logic                         cmd_full, cmd_empty, cmd_pop;
  logic                         init_busy;

  out_item_t                    res;
  logic [$bits(out_item_t)-1:0] out_rdata;
  logic                         res_push, res_full;

  // Configuration: pready tied high, one attribute register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ATTRIBUTE);
  assign prdata = (paddr[2] == REG_ATTRIBUTE) ? {24'b0, attr_r} : '0;

  always_comb begin
    attr_nxt = attr_r;
    if (cfg_wr) begin
      attr_nxt = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // Hold off input while the post-reset blanking sweep runs
  assign full = cmd_full || init_busy;

  // Front: classify each transaction into a back-end operation
  tccs_front #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_front (
    .item (in_item),
    .cmd  (cmd_in)
  );

  tccs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && !full),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rdata);

  // Back: screen memory, cursor and the scroll / clear sequencer
  tccs_back #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .attr      (attr_r),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .init_busy (init_busy)
  );

  tccs_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_item = out_item_t'(out_rdata);

endmodule

`default_nettype wire

// ===== hdl/tccs_fifo.sv =====
`default_nettype none

module tccs_fifo import tccs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [IW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tccs_front.sv =====
`default_nettype none

module tccs_front import tccs_pkg::*; #(
  parameter int ROW_COUNT = 25,
  parameter int COL_COUNT = 80
) (
  input  wire in_item_t item,
  output cmd_t          cmd
);

  always_comb begin
    cmd.char_code = item.char_code;
    cmd.read_row  = item.read_row;
    cmd.read_col  = item.read_col;
    cmd.in_range  = (32'(item.read_row) < ROW_COUNT) && (32'(item.read_col) < COL_COUNT);
    unique case (item.action)
      ACT_PUT: begin
        cmd.op = (item.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      ACT_CLEAR: cmd.op = OP_CLEAR;
      ACT_READ:  cmd.op = OP_READ;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/tccs_back.sv =====
`default_nettype none

module tccs_back import tccs_pkg::*; #(
  parameter int ROW_COUNT = 25,
  parameter int COL_COUNT = 80
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire cmd_t              cmd,
  output logic                   cmd_pop,
  input  wire logic [ATTR_W-1:0] attr,
  input  wire logic              res_full,
  output logic                   res_push,
  output out_item_t              res,
  output logic                   init_busy
);

  localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int CW  = $clog2(CELL_COUNT + 1);
  localparam int RW  = $clog2(ROW_COUNT);
  localparam int CLW = $clog2(COL_COUNT);

  localparam logic [CW-1:0]  CELL_END    = CW'(CELL_COUNT);
  localparam logic [CW-1:0]  CELL_LAST   = CW'(CELL_COUNT - 1);
  localparam logic [CW-1:0]  COL_START   = CW'(COL_COUNT);
  localparam logic [CW-1:0]  COL_P1      = CW'(COL_COUNT + 1);
  localparam logic [CW-1:0]  BOTTOM_ROW  = CW'(CELL_COUNT - COL_COUNT);
  localparam logic [RW-1:0]  ROW_LAST    = RW'(ROW_COUNT - 1);
  localparam logic [CLW-1:0] COL_LAST    = CLW'(COL_COUNT - 1);

  localparam logic [1:0] S_RUN    = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_FILL   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CLW-1:0]    col_r, col_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic              init_r, init_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              read_ok_r, read_ok_nxt;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [AW-1:0]     cur_addr, req_addr;
  logic [CW-1:0]     copy_dst;
  logic              wrap;

  assign cur_addr  = AW'(row_r * COL_COUNT) + AW'(col_r);
  assign req_addr  = AW'(cmd.read_row * COL_COUNT) + AW'(cmd.read_col);
  assign copy_dst  = ptr_r - COL_P1;
  assign init_busy = init_r;

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    fill_val_nxt = fill_val_r;
    init_nxt     = init_r;
    scrolled_nxt = scrolled_r;
    read_ok_nxt  = read_ok_r;
    cmd_pop      = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = cur_addr;
    raddr        = req_addr;
    wdata        = fill_val_r;
    wrap         = 1'b0;
    res_push     = 1'b0;
    res.cell_value     = '0;
    res.scrolled       = 1'b0;

    unique case (state_r)
      S_RUN: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_PUT: begin
              we    = 1'b1;
              wdata = {attr, cmd.char_code};
              if (col_r == COL_LAST) begin
                wrap = 1'b1;
              end else begin
                col_nxt  = col_r + 1'b1;
                res_push = 1'b1;
              end
            end
            OP_NEWLINE: wrap = 1'b1;
            OP_CLEAR: begin
              row_nxt      = '0;
              col_nxt      = '0;
              ptr_nxt      = '0;
              fill_val_nxt = {attr, SPACE_CODE};
              scrolled_nxt = 1'b0;
              state_nxt    = S_FILL;
            end
            OP_READ: begin
              re          = cmd.in_range;
              read_ok_nxt = cmd.in_range;
              state_nxt   = S_READ;
            end
            default: res_push = 1'b1;
          endcase
          if (wrap) begin
            col_nxt = '0;
            if (row_r == ROW_LAST) begin
              // Last row: shift the screen up one row, then blank the bottom row
              ptr_nxt      = COL_START;
              fill_val_nxt = {attr, SPACE_CODE};
              scrolled_nxt = 1'b1;
              state_nxt    = S_SCROLL;
            end else begin
              row_nxt  = row_r + 1'b1;
              res_push = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        res_push       = 1'b1;
        res.cell_value = read_ok_r ? rd_data_r : '0;
        state_nxt      = S_RUN;
      end
      S_SCROLL: begin
        // Read one row ahead, write the data fetched last cycle one row up
        if (ptr_r < CELL_END) begin
          re    = 1'b1;
          raddr = ptr_r[AW-1:0];
        end
        if (ptr_r > COL_START) begin
          we    = 1'b1;
          waddr = copy_dst[AW-1:0];
          wdata = rd_data_r;
        end
        if (ptr_r == CELL_END) begin
          ptr_nxt   = BOTTOM_ROW;
          state_nxt = S_FILL;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = ptr_r[AW-1:0];
        wdata = fill_val_r;
        if (ptr_r == CELL_LAST) begin
          if (init_r) begin
            init_nxt = 1'b0;
          end else begin
            res_push     = 1'b1;
            res.scrolled = scrolled_r;
          end
          state_nxt = S_RUN;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: state_nxt = S_RUN;
    endcase

    res.cursor_row_now = ROW_FIELD_W'(row_nxt);
    res.cursor_col_now = COL_FIELD_W'(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_FILL;
      ptr_r      <= '0;
      row_r      <= '0;
      col_r      <= '0;
      fill_val_r <= RESET_BLANK;
      init_r     <= 1'b1;
      scrolled_r <= 1'b0;
      read_ok_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fill_val_r <= fill_val_nxt;
      init_r     <= init_nxt;
      scrolled_r <= scrolled_nxt;
      read_ok_r  <= read_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      screen[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= screen[raddr];
    end
  end

endmodule

`default_nettype wire
